[rtl/msmg_pkg.sv]
// ----------------------------------------------------------------------------
// msmg_pkg: shared types, constants and the edge function
// Pixel and column types, queue entry layout and the per-band Sobel kernel
// ----------------------------------------------------------------------------
package msmg_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int BAND_COUNT = 4;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef logic [BAND_COUNT*8-1:0] t_px;
    // column of three pixels: [0] top, [1] middle, [2] bottom
    typedef t_px [2:0] t_col;

    typedef struct packed {
        t_col              left;
        t_col              mid;
        t_col              right;
        logic [15:0]       row;
        logic [COL_W-1:0]  col;
        logic              last_col;
        logic              last_row;
    } t_entry;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_EDGE,
        PH_LAST,
        PH_CORNER
    } t_phase;

    // max over bands of (|gx|+|gy|)/2 rounded half to even, clamped to 255
    function automatic logic [7:0] edge_value(input t_col l, input t_col m, input t_col r);
        logic [10:0] best;
        logic signed [12:0] gx;
        logic signed [12:0] gy;
        logic [11:0] s;
        logic [10:0] q;
        logic signed [12:0] l0, l1, l2, m0, m2, r0, r1, r2;
        best = '0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            l0 = 13'(l[0][b*8 +: 8]);
            l1 = 13'(l[1][b*8 +: 8]);
            l2 = 13'(l[2][b*8 +: 8]);
            m0 = 13'(m[0][b*8 +: 8]);
            m2 = 13'(m[2][b*8 +: 8]);
            r0 = 13'(r[0][b*8 +: 8]);
            r1 = 13'(r[1][b*8 +: 8]);
            r2 = 13'(r[2][b*8 +: 8]);
            gx = (r0 + (r1 <<< 1) + r2) - (l0 + (l1 <<< 1) + l2);
            gy = (l2 + (m2 <<< 1) + r2) - (l0 + (m0 <<< 1) + r0);
            s = 12'(gx < 0 ? -gx : gx) + 12'(gy < 0 ? -gy : gy);
            q = s[11:1] + 11'(s[0] & s[1]);
            if (q > best) begin
                best = q;
            end
        end
        return (best > 11'd255) ? 8'd255 : best[7:0];
    endfunction

endpackage

[rtl/msmg_front.sv]
// ----------------------------------------------------------------------------
// msmg_front: raster tracking, line stores and column window
// Reads two line stores per pixel and builds the 3x3 window of each request
// ----------------------------------------------------------------------------
module msmg_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  msmg_pkg::t_px          i_pixel,
    input  logic [12:0]            i_width,
    input  logic [15:0]            i_height,
    input  logic                   i_restart,
    output logic                   o_busy,
    output logic                   o_push,
    output msmg_pkg::t_entry       o_entry
);
    import msmg_pkg::*;

    logic [COL_W-1:0] r_col_cnt, n_col_cnt;
    logic [15:0]      r_row_cnt, n_row_cnt;
    logic [12:0]      w_eff;
    logic [15:0]      h_eff;
    logic [COL_W-1:0] a_col;
    logic [15:0]      a_row;
    logic             a_last_col, a_last_row;

    // second stage registers
    logic             r_b_valid;
    t_px              r_b_cur;
    logic [COL_W-1:0] r_b_col;
    logic [15:0]      r_b_row;
    logic             r_b_last_col, r_b_last_row;
    t_px              r_rd_up, r_rd_lo;
    t_col             r_win_a, r_win_b;
    t_col             cn, left;

    t_px r_mem_up [MAX_WIDTH];
    t_px r_mem_lo [MAX_WIDTH];

    // clamp geometry and raster position
    always_comb begin
        w_eff = (i_width < 13'd2) ? 13'd2 :
                (i_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : i_width;
        h_eff = (i_height < 16'd2) ? 16'd2 : i_height;
        a_col = (13'(r_col_cnt) >= w_eff) ? COL_W'(w_eff - 13'd1) : r_col_cnt;
        a_row = (r_row_cnt >= h_eff) ? (h_eff - 16'd1) : r_row_cnt;
        a_last_col = (13'(a_col) == w_eff - 13'd1);
        a_last_row = (a_row == h_eff - 16'd1);
        if (a_last_col) begin
            n_col_cnt = '0;
            n_row_cnt = a_last_row ? 16'd0 : a_row + 16'd1;
        end else begin
            n_col_cnt = a_col + COL_W'(1);
            n_row_cnt = a_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (i_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // line stores: read at accept, written back in the following cycle
    always_ff @(posedge i_clk) begin
        r_rd_up <= r_mem_up[a_col];
        r_rd_lo <= r_mem_lo[a_col];
        if (r_b_valid) begin
            r_mem_up[r_b_col] <= r_rd_lo;
            r_mem_lo[r_b_col] <= r_b_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= i_accept;
        end
        r_b_cur      <= i_pixel;
        r_b_col      <= a_col;
        r_b_row      <= a_row;
        r_b_last_col <= a_last_col;
        r_b_last_row <= a_last_row;
    end

    // current column and left neighbor with mirrored edge
    always_comb begin
        cn[0] = (r_b_row == 16'd1) ? r_b_cur : r_rd_up;
        cn[1] = r_rd_lo;
        cn[2] = r_b_cur;
        left  = (r_b_col == COL_W'(1)) ? cn : r_win_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_a <= '0;
            r_win_b <= '0;
        end else if (r_b_valid) begin
            r_win_a <= r_win_b;
            r_win_b <= cn;
        end
    end

    assign o_busy = r_b_valid;
    assign o_push = r_b_valid && (r_b_row != 16'd0) && (r_b_col != '0);
    always_comb begin
        o_entry.left     = left;
        o_entry.mid      = r_win_b;
        o_entry.right    = cn;
        o_entry.row      = r_b_row;
        o_entry.col      = r_b_col;
        o_entry.last_col = r_b_last_col;
        o_entry.last_row = r_b_last_row;
    end

endmodule

[rtl/msmg_queue.sv]
// ----------------------------------------------------------------------------
// msmg_queue: window queue between front and back
// Small fifo of window entries with an occupancy count
// ----------------------------------------------------------------------------
module msmg_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  msmg_pkg::t_entry          i_entry,
    input  logic                      i_pop,
    output logic                      o_valid,
    output msmg_pkg::t_entry          o_entry,
    output logic [msmg_pkg::QCNT_W-1:0] o_count
);
    import msmg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_entry             r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_head, r_tail;
    logic [QCNT_W-1:0]  r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_tail] <= i_entry;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + PTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + PTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_entry = r_buf[r_head];
    assign o_count = r_count;

endmodule

[rtl/msmg_back.sv]
// ----------------------------------------------------------------------------
// msmg_back: edge evaluation and result sequencing
// Emits up to four results per window entry through an output register
// ----------------------------------------------------------------------------
module msmg_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  msmg_pkg::t_entry       i_entry,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_edge_strength,
    output logic [15:0]            o_out_row,
    output logic [11:0]            o_out_col,
    output logic                   o_run_last,
    output logic                   o_frame_end
);
    import msmg_pkg::*;

    t_phase r_phase, n_phase;
    logic   load, done;
    t_col   sl, sm, sr, tl, tm, tr;
    logic   r_valid;
    logic [7:0]  r_edge;
    logic [15:0] r_row;
    logic [11:0] r_col;
    logic        r_last, r_fend;
    logic [15:0] res_row;
    logic [11:0] res_col;
    logic        odd, low;

    assign load = i_valid && (!r_valid || !i_stall);

    // next phase
    always_comb begin
        n_phase = r_phase;
        done    = 1'b0;
        unique case (r_phase)
            PH_MAIN: begin
                if (i_entry.last_col) n_phase = PH_EDGE;
                else if (i_entry.last_row) n_phase = PH_LAST;
                else done = 1'b1;
            end
            PH_EDGE: begin
                if (i_entry.last_row) n_phase = PH_LAST;
                else done = 1'b1;
            end
            PH_LAST: begin
                if (i_entry.last_col) n_phase = PH_CORNER;
                else done = 1'b1;
            end
            PH_CORNER: done = 1'b1;
            default: done = 1'b1;
        endcase
        if (done) begin
            n_phase = PH_MAIN;
        end
    end

    // window selection per phase
    always_comb begin
        odd = (r_phase == PH_EDGE) || (r_phase == PH_CORNER);
        low = (r_phase == PH_LAST) || (r_phase == PH_CORNER);
        sl  = odd ? i_entry.mid   : i_entry.left;
        sm  = odd ? i_entry.right : i_entry.mid;
        sr  = odd ? i_entry.mid   : i_entry.right;
        // last row mirrors the previous row on both sides
        tl  = low ? {sl[1], sl[2], sl[1]} : sl;
        tm  = low ? {sm[1], sm[2], sm[1]} : sm;
        tr  = low ? {sr[1], sr[2], sr[1]} : sr;
        res_row = low ? i_entry.row : i_entry.row - 16'd1;
        res_col = odd ? 12'(i_entry.col) : 12'(i_entry.col - COL_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAIN;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_edge <= edge_value(tl, tm, tr);
            r_row  <= res_row;
            r_col  <= res_col;
            r_last <= done;
            r_fend <= (r_phase == PH_CORNER);
        end
    end

    assign o_pop           = load && done;
    assign o_valid         = r_valid;
    assign o_edge_strength = r_edge;
    assign o_out_row       = r_row;
    assign o_out_col       = r_col;
    assign o_run_last      = r_last;
    assign o_frame_end     = r_fend;

endmodule

[rtl/multiband_sobel_max_gradient.sv]
// ----------------------------------------------------------------------------
// multiband_sobel_max_gradient: four-band Sobel edge strength, raster stream
// Max over bands of the halved L1 Sobel gradient with mirrored borders
// ----------------------------------------------------------------------------
// Usage:
//   input channel: i_valid / o_stall with four band pixels in raster order
//   output channel: o_valid / i_stall with edge strength, row, column,
//   run_last (last result of an input pixel) and frame_end
//   config: i_cfg_we / i_cfg_idx / i_cfg_data, width (0) and height (1);
//   a write to either restarts the raster at row 0, column 0; write only when idle
// Throughput: one pixel per cycle; the back end emits one result per cycle
//   while unstalled, so the pixel closing a row (two results), every pixel of
//   the last row (two results) and the frame's final pixel (four) hold the
//   source back once the four-entry queue has absorbed the extra cycles
// Path: an accepted pixel passes the line store read with window stage, the
//   queue and the output register in that order before its result is presented
// Row 0 is stored and produces nothing; output row r comes with input row
//   r+1, and the last row comes together with the row before it
// Reset clears position, window and handshakes and loads 640 x 480; line
//   stores need no clearing. A stalled receiver holds the output register;
//   the queue fills and o_stall rises to back-pressure the source
// ----------------------------------------------------------------------------
module multiband_sobel_max_gradient (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_band0_pixel,
    input  logic [7:0]  i_band1_pixel,
    input  logic [7:0]  i_band2_pixel,
    input  logic [7:0]  i_band3_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_edge_strength,
    output logic [15:0] o_out_row,
    output logic [11:0] o_out_col,
    output logic        o_run_last,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import msmg_pkg::*;

    logic [12:0]       r_width;
    logic [15:0]       r_height;
    logic              restart, accept, busy, push, pop, q_valid;
    t_entry            f_entry, q_entry;
    logic [QCNT_W-1:0] q_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd640;
            r_height <= 16'd480;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WIDTH) r_width <= i_cfg_data[12:0];
            if (i_cfg_idx == REG_HEIGHT) r_height <= i_cfg_data;
        end
    end
    assign restart = i_cfg_we && ((i_cfg_idx == REG_WIDTH) || (i_cfg_idx == REG_HEIGHT));

    // credit check: queue plus in-flight request must fit
    assign o_stall = (QCNT_W'(q_count) + QCNT_W'(busy)) >= QCNT_W'(QUEUE_DEPTH);
    assign accept  = i_valid && !o_stall;

    msmg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_pixel   ({i_band3_pixel, i_band2_pixel, i_band1_pixel, i_band0_pixel}),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_restart (restart),
        .o_busy    (busy),
        .o_push    (push),
        .o_entry   (f_entry)
    );

    msmg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    msmg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_entry         (q_entry),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_edge_strength (o_edge_strength),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_run_last      (o_run_last),
        .o_frame_end     (o_frame_end)
    );

endmodule
